### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the periodic wrap block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under asynchronous reset
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication after a fixed number of cycles
`define AST_DELAY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
		else $error("latency assertion failed");

`endif

### design/pbw_pkg.sv
// ----------------------------------------------------------------------------
// pbw_pkg
// Widths, register indexes, types and helpers for the periodic wrap block.
// ----------------------------------------------------------------------------
package pbw_pkg;

	localparam int COORD_W       = 32;
	localparam int ELEM_W        = 21;
	localparam int ELEM_FRAC     = 16;
	localparam int ROW_W         = 3 * ELEM_W;
	localparam int LEN_RAW_W     = 20;
	localparam int BOX_W         = 3 * LEN_RAW_W;
	localparam int MODE_W        = 5;
	localparam int CFG_IDX_W     = 4;

	// skew and cell coordinate widths after a row sum and rounding
	localparam int SKEW_W        = COORD_W + ELEM_W + 2 - ELEM_FRAC;
	localparam int CART_W        = SKEW_W + ELEM_W + 2 - ELEM_FRAC;

	// divider: magnitude bits, two per stage
	localparam int DIV_BITS      = SKEW_W + 1;
	localparam int DIV_STAGES    = (DIV_BITS + 1) / 2;
	localparam int MATMUL_LAT    = 2;
	localparam int WRAP_LAT      = DIV_STAGES + 2;

	localparam int COORD_FRAC_BITS_DEF = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INV0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV1 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV2 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FWD0 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FWD1 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FWD2 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BOX  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 4'd7;

	// mode flag bits
	localparam int MODE_CART = 3;
	localparam int MODE_POS  = 4;
	localparam logic [MODE_W-1:0] MODE_RESET = 5'd8;
	localparam logic [ELEM_W-1:0] ELEM_ONE   = 21'd65536;

	typedef logic [ROW_W-1:0] row_t;
	typedef row_t [2:0] matrix_t;

	typedef struct packed {
		logic                 periodic;
		logic                 positive;
		logic [LEN_RAW_W-1:0] raw_len;
	} axis_cfg_t;

	// clamp a cell coordinate to the signed 32-bit range
	function automatic logic [COORD_W-1:0] sat_coord(input logic [CART_W-1:0] v);
		logic [CART_W-COORD_W:0] hi;
		logic [COORD_W-1:0]      r;
		hi = v[CART_W-1:COORD_W-1];
		if (hi == '0 || hi == '1) begin
			r = v[COORD_W-1:0];
		end else if (v[CART_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

### design/pbw_matmul.sv
// ----------------------------------------------------------------------------
// pbw_matmul
// Two-stage 3x3 matrix times vector or pass-through, Q4.16 elements, rounded half up.
// ----------------------------------------------------------------------------
module pbw_matmul #(
	parameter int IN_W  = pbw_pkg::COORD_W,
	parameter int OUT_W = IN_W + pbw_pkg::ELEM_W + 2 - pbw_pkg::ELEM_FRAC
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  pbw_pkg::matrix_t          rows,
	input  logic                      bypass,
	input  logic [2:0][IN_W-1:0]      vec_in,
	output logic                      out_valid,
	output logic [2:0][OUT_W-1:0]     vec_out
);
	import pbw_pkg::*;

	localparam int PW   = IN_W + ELEM_W;
	localparam int SUMW = PW + 2;

	logic signed [PW-1:0]   prod_s1 [3][3];
	logic [2:0][IN_W-1:0]   vec_s1;
	logic                   valid_s1;
	logic                   valid_s2;
	logic [2:0][OUT_W-1:0]  sum_rnd;

	// stage 1: nine products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[i][j] <= $signed(rows[i][ELEM_W*j +: ELEM_W]) * $signed(vec_in[j]);
			end
		end
		vec_s1 <= vec_in;
	end

	// row sums, add half an lsb, floor shift
	always_comb begin
		logic signed [SUMW-1:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = SUMW'(prod_s1[i][0]) + SUMW'(prod_s1[i][1]) + SUMW'(prod_s1[i][2])
				+ (SUMW'(1) <<< (ELEM_FRAC - 1));
			sum_rnd[i] = acc[ELEM_FRAC +: OUT_W];
		end
	end

	// stage 2: result or pass-through
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vec_out[i] <= bypass ? OUT_W'($signed(vec_s1[i])) : sum_rnd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;

endmodule

### design/pbw_wrap_axis.sv
// ----------------------------------------------------------------------------
// pbw_wrap_axis
// Wraps one skew coordinate into its periodic window with a pipelined
// restoring divider that keeps only the floor remainder.
// ----------------------------------------------------------------------------
module pbw_wrap_axis #(
	parameter int COORD_FRAC_BITS = pbw_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [pbw_pkg::SKEW_W-1:0]  s_in,
	input  pbw_pkg::axis_cfg_t          cfg,
	output logic                        out_valid,
	output logic [pbw_pkg::SKEW_W-1:0]  w_out
);
	import pbw_pkg::*;
	`include "assert_macros.svh"

	localparam int LSH = (COORD_FRAC_BITS >= 10) ? COORD_FRAC_BITS - 10 : 0;
	localparam int RSH = (COORD_FRAC_BITS < 10) ? 10 - COORD_FRAC_BITS : 0;
	localparam int LW  = LEN_RAW_W + LSH;
	localparam int DW  = LW + 1;
	localparam int AW  = SKEW_W + 2;
	localparam int MPW = 2 * DIV_STAGES;

	logic [LW-1:0]           len;
	logic [DW-1:0]           dvs;
	logic                    skip;
	logic signed [AW-1:0]    s_ext;
	logic signed [AW-1:0]    dvd;
	logic [AW-1:0]           mag;

	logic [DW-1:0]           rem_s  [DIV_STAGES+1];
	logic [MPW-1:0]          mag_s  [DIV_STAGES+1];
	logic [SKEW_W-1:0]       sv_s   [DIV_STAGES+1];
	logic                    neg_s  [DIV_STAGES+1];
	logic                    skip_s [DIV_STAGES+1];
	logic                    vld_s  [DIV_STAGES+1];

	logic [DW-1:0]           r_fin;
	logic signed [DW:0]      ctr_diff;
	logic [SKEW_W-1:0]       w_nxt;
	logic                    wrapped_sf;

	// box length in coordinate format; divisor is L or 2L
	assign len  = (LW'(cfg.raw_len) << LSH) >> RSH;
	assign skip = !cfg.periodic || (len == '0);
	assign dvs  = cfg.positive ? DW'(len) : {len, 1'b0};

	// dividend s or 2s+L, folded to a magnitude: floor(a/d) = ~(~a/d) for a < 0
	assign s_ext = AW'($signed(s_in));
	assign dvd   = cfg.positive ? s_ext : (s_ext <<< 1) + $signed(AW'(len));
	assign mag   = dvd[AW-1] ? ~dvd : dvd;

	// prep stage
	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		mag_s[0]  <= MPW'(mag[DIV_BITS-1:0]);
		sv_s[0]   <= s_in;
		neg_s[0]  <= dvd[AW-1];
		skip_s[0] <= skip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// divider stages, two remainder bits per stage
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		logic [DW-1:0] rem_nxt;

		always_comb begin
			logic [DW:0]   t;
			logic [DW-1:0] r;
			r = rem_s[g];
			for (int b = 0; b < 2; b++) begin
				t = {r, mag_s[g][MPW-1-b]};
				if (t >= {1'b0, dvs}) begin
					t = t - {1'b0, dvs};
				end
				r = t[DW-1:0];
			end
			rem_nxt = r;
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= rem_nxt;
			mag_s[g+1]  <= mag_s[g] << 2;
			sv_s[g+1]   <= sv_s[g];
			neg_s[g+1]  <= neg_s[g];
			skip_s[g+1] <= skip_s[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
	end

	// floor remainder, then window placement
	always_comb begin
		r_fin    = neg_s[DIV_STAGES] ? dvs - DW'(1) - rem_s[DIV_STAGES] : rem_s[DIV_STAGES];
		ctr_diff = $signed({1'b0, r_fin}) - $signed((DW + 1)'(len));
		if (skip_s[DIV_STAGES]) begin
			w_nxt = sv_s[DIV_STAGES];
		end else if (cfg.positive) begin
			w_nxt = SKEW_W'(r_fin);
		end else begin
			w_nxt = SKEW_W'(ctr_diff >>> 1);
		end
	end

	// output stage
	always_ff @(posedge clk) begin
		w_out      <= w_nxt;
		wrapped_sf <= !skip_s[DIV_STAGES];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[DIV_STAGES];
		end
	end

	`AST_DELAY(a_wrap_lat, clk, arst_n, in_valid, WRAP_LAT, out_valid)
	`AST_IMPLIES(a_pos_nonneg, clk, arst_n, out_valid && wrapped_sf && cfg.positive, !w_out[SKEW_W-1])

endmodule

### design/periodic_box_position_wrap.sv
// ----------------------------------------------------------------------------
// periodic_box_position_wrap
// Periodic boundary wrap of one atom position in a triclinic cell:
// inverse matrix, per-axis window wrap, forward matrix, saturation.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------
//  position  | start, busy (beat: start&!busy) | pos_x, pos_y, pos_z
//  result    | done (one-cycle strobe)    | wrapped_x, wrapped_y, wrapped_z
//  config    | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
//  One beat is taken every cycle; busy stays low.
//  Each beat passes the inverse matrix, the per-axis wrap with its
//  two-bit-per-stage remainder pipeline, the forward matrix and saturation.
//  Reset clears the valid chain and loads identity matrices, zero lengths
//  and Cartesian mode. The result side takes every strobe, so nothing stalls.
// ----------------------------------------------------------------------------
module periodic_box_position_wrap #(
	parameter int COORD_FRAC_BITS = pbw_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [pbw_pkg::COORD_W-1:0]   pos_x,
	input  logic signed [pbw_pkg::COORD_W-1:0]   pos_y,
	input  logic signed [pbw_pkg::COORD_W-1:0]   pos_z,
	output logic                                 done,
	output logic signed [pbw_pkg::COORD_W-1:0]   wrapped_x,
	output logic signed [pbw_pkg::COORD_W-1:0]   wrapped_y,
	output logic signed [pbw_pkg::COORD_W-1:0]   wrapped_z,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pbw_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pbw_pkg::ROW_W-1:0]            cfg_data
);
	import pbw_pkg::*;
	`include "assert_macros.svh"

	localparam int TOT_LAT = MATMUL_LAT + WRAP_LAT + MATMUL_LAT + 1;

	matrix_t              inv_q;
	matrix_t              fwd_q;
	logic [BOX_W-1:0]     box_q;
	logic [MODE_W-1:0]    mode_q;

	logic                     in_beat;
	logic                     skew_valid;
	logic [2:0][SKEW_W-1:0]   skew;
	logic [2:0]               wrap_valid;
	logic [2:0][SKEW_W-1:0]   wrapped;
	logic                     cell_valid;
	logic [2:0][CART_W-1:0]   cart_vec;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_beat   = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				inv_q[i] <= ROW_W'(ELEM_ONE) << (ELEM_W * i);
				fwd_q[i] <= ROW_W'(ELEM_ONE) << (ELEM_W * i);
			end
			box_q  <= '0;
			mode_q <= MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INV0: inv_q[0] <= cfg_data;
				REG_INV1: inv_q[1] <= cfg_data;
				REG_INV2: inv_q[2] <= cfg_data;
				REG_FWD0: fwd_q[0] <= cfg_data;
				REG_FWD1: fwd_q[1] <= cfg_data;
				REG_FWD2: fwd_q[2] <= cfg_data;
				REG_BOX:  box_q    <= cfg_data[BOX_W-1:0];
				REG_MODE: mode_q   <= cfg_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// position to skew coordinates
	pbw_matmul #(.IN_W(COORD_W), .OUT_W(SKEW_W)) u_inv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_beat),
		.rows      (inv_q),
		.bypass    (mode_q[MODE_CART]),
		.vec_in    ({pos_z, pos_y, pos_x}),
		.out_valid (skew_valid),
		.vec_out   (skew)
	);

	// per-axis wrap
	for (genvar a = 0; a < 3; a++) begin : g_axis
		axis_cfg_t acfg;

		assign acfg = '{periodic: mode_q[a], positive: mode_q[MODE_POS],
			raw_len: box_q[LEN_RAW_W*a +: LEN_RAW_W]};

		pbw_wrap_axis #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_wrap (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (skew_valid),
			.s_in      (skew[a]),
			.cfg       (acfg),
			.out_valid (wrap_valid[a]),
			.w_out     (wrapped[a])
		);
	end

	// skew back to cell coordinates
	pbw_matmul #(.IN_W(SKEW_W), .OUT_W(CART_W)) u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (&wrap_valid),
		.rows      (fwd_q),
		.bypass    (mode_q[MODE_CART]),
		.vec_in    (wrapped),
		.out_valid (cell_valid),
		.vec_out   (cart_vec)
	);

	// saturate and register the result beat
	always_ff @(posedge clk) begin
		wrapped_x <= sat_coord(cart_vec[0]);
		wrapped_y <= sat_coord(cart_vec[1]);
		wrapped_z <= sat_coord(cart_vec[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cell_valid;
		end
	end

	`AST_DELAY(a_item_done, clk, arst_n, in_beat, TOT_LAT, done)

endmodule

### dv/periodic_box_position_wrap_tb.sv
// ----------------------------------------------------------------------------
// periodic_box_position_wrap_tb
// Self-checking bench for the periodic wrap block. Positions are streamed in
// under random idle bursts across many register settings (Cartesian and
// skewed cells, centred and positive windows, zero and full box lengths).
// A scoreboard predicts every wrapped position and compares it on the strobe.
// ----------------------------------------------------------------------------
module periodic_box_position_wrap_tb;
	import pbw_pkg::*;

	localparam int FRAC       = COORD_FRAC_BITS_DEF;
	localparam int PIPE_LAT   = 2 + WRAP_LAT + 2 + 1;
	localparam int N_PHASES   = 14;
	localparam int PHASE_BEATS = 100;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} coord_t;

	// ------------------------------------------------------------------------
	// scoreboard: own copy of the registers, wrap predictor, expected queue
	// ------------------------------------------------------------------------
	class wrap_scoreboard;
		logic [ROW_W-1:0] inv_rows[3];
		logic [ROW_W-1:0] fwd_rows[3];
		logic [BOX_W-1:0] lengths;
		logic [MODE_W-1:0] mode;
		coord_t wrapped_q[$];
		int failures;

		function new();
			for (int i = 0; i < 3; i++) begin
				inv_rows[i] = ROW_W'(ELEM_ONE) << (ELEM_W * i);
				fwd_rows[i] = ROW_W'(ELEM_ONE) << (ELEM_W * i);
			end
			lengths = '0;
			mode = MODE_RESET;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
			case (idx)
				REG_INV0, REG_INV1, REG_INV2: inv_rows[idx - REG_INV0] = data;
				REG_FWD0, REG_FWD1, REG_FWD2: fwd_rows[idx - REG_FWD0] = data;
				REG_BOX:  lengths = data[BOX_W-1:0];
				REG_MODE: mode = data[MODE_W-1:0];
				default: ; // unknown index: ignored
			endcase
		endfunction

		function longint elem(logic [ROW_W-1:0] row, int col);
			logic signed [ELEM_W-1:0] e;
			e = row[ELEM_W*col +: ELEM_W];
			return longint'(e);
		endfunction

		function longint floor_quot(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0) q -= 1;
			return q;
		endfunction

		// row sums in full width, rounded half up to Q16
		function void cell_product(logic [ROW_W-1:0] rows[3], longint v[3],
				output longint r[3]);
			longint acc;
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) acc += elem(rows[i], j) * v[j];
				r[i] = (acc + (longint'(1) << (ELEM_FRAC - 1))) >>> ELEM_FRAC;
			end
		endfunction

		function longint axis_len(int ax);
			longint raw;
			raw = longint'(lengths[LEN_RAW_W*ax +: LEN_RAW_W]);
			if (FRAC >= 10) return raw << (FRAC - 10);
			return raw >> (10 - FRAC);
		endfunction

		function logic [COORD_W-1:0] clamp32(longint v);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			return v[COORD_W-1:0];
		endfunction

		function void note_position(coord_t p);
			longint pv[3], sk[3], cc[3];
			longint len, k;
			coord_t w;
			pv[0] = longint'(p.x);
			pv[1] = longint'(p.y);
			pv[2] = longint'(p.z);
			if (mode[MODE_CART]) sk = pv;
			else cell_product(inv_rows, pv, sk);
			for (int i = 0; i < 3; i++) begin
				len = axis_len(i);
				if (mode[i] && len != 0) begin
					if (mode[MODE_POS]) k = floor_quot(sk[i], len);
					else k = floor_quot(2 * sk[i] + len, 2 * len);
					sk[i] -= k * len;
				end
			end
			if (mode[MODE_CART]) cc = sk;
			else cell_product(fwd_rows, sk, cc);
			w.x = clamp32(cc[0]);
			w.y = clamp32(cc[1]);
			w.z = clamp32(cc[2]);
			wrapped_q.push_back(w);
		endfunction

		function void check_result(coord_t got);
			coord_t exp_w;
			if (wrapped_q.size() == 0) begin
				$error("result beat with no position outstanding");
				failures++;
				return;
			end
			exp_w = wrapped_q.pop_front();
			if (got.x !== exp_w.x) begin
				$error("wrapped_x: expected %0d, got %0d", exp_w.x, got.x);
				failures++;
			end
			if (got.y !== exp_w.y) begin
				$error("wrapped_y: expected %0d, got %0d", exp_w.y, got.y);
				failures++;
			end
			if (got.z !== exp_w.z) begin
				$error("wrapped_z: expected %0d, got %0d", exp_w.z, got.z);
				failures++;
			end
		endfunction

		function int pending();
			return wrapped_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
	logic done;
	logic signed [COORD_W-1:0] wrapped_x, wrapped_y, wrapped_z;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ROW_W-1:0] cfg_data;

	wrap_scoreboard sb;
	int pos_beats;
	int cfg_beats;
	bit allow_idle;

	periodic_box_position_wrap u_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.done(done),
		.wrapped_x(wrapped_x), .wrapped_y(wrapped_y), .wrapped_z(wrapped_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// monitor: beats are taken at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
				cfg_beats++;
			end
			if (start && !busy) begin
				sb.note_position({pos_z, pos_y, pos_x});
				pos_beats++;
			end
			if (done) sb.check_result({wrapped_z, wrapped_y, wrapped_x});
		end
	end

	// ------------------------------------------------------------------------
	// drivers, all working from the falling edge
	// ------------------------------------------------------------------------
	task automatic idle_gap();
		int n;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 5);
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_position(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z);
		int seen;
		idle_gap();
		seen = pos_beats;
		start = 1'b1;
		pos_x = x;
		pos_y = y;
		pos_z = z;
		do @(negedge clk); while (pos_beats == seen);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		int seen;
		seen = cfg_beats;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(negedge clk); while (cfg_beats == seen);
		cfg_valid = 1'b0;
	endtask

	// wait for every expected beat, then let the pipeline empty
	task automatic drain();
		start = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	function automatic logic [ELEM_W-1:0] rand_elem(bit diag);
		logic signed [ELEM_W-1:0] e;
		case ($urandom_range(0, 3))
			0: e = ELEM_W'($urandom);
			1: e = ELEM_W'($urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000);
			default: e = ELEM_W'(int'(diag ? ELEM_ONE : '0)
					+ int'($urandom_range(0, 16383)) - 8192);
		endcase
		return e;
	endfunction

	function automatic logic [ROW_W-1:0] rand_row(int r);
		logic [ROW_W-1:0] row;
		for (int c = 0; c < 3; c++) row[ELEM_W*c +: ELEM_W] = rand_elem(c == r);
		return row;
	endfunction

	function automatic logic [LEN_RAW_W-1:0] rand_len();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return LEN_RAW_W'($urandom);
			default: return LEN_RAW_W'($urandom_range(1, 4096));
		endcase
	endfunction

	// positions: full range, small, or close to a multiple of half the box
	function automatic logic [COORD_W-1:0] rand_coord(int ax);
		longint len, v;
		len = longint'(sb.lengths[LEN_RAW_W*ax +: LEN_RAW_W]) << (FRAC - 10);
		case ($urandom_range(0, 3))
			0: v = longint'($signed($urandom));
			1: v = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
			default: v = longint'($urandom_range(0, 16)) * len / 2
					* ($urandom_range(0, 1) ? 1 : -1) + $urandom_range(0, 6) - 3;
		endcase
		return v[COORD_W-1:0];
	endfunction

	task automatic random_config(int phase);
		logic [ROW_W-1:0] box;
		for (int r = 0; r < 3; r++)
			write_reg(CFG_IDX_W'(int'(REG_INV0) + r), rand_row(r));
		for (int r = 0; r < 3; r++)
			write_reg(CFG_IDX_W'(int'(REG_FWD0) + r), rand_row(r));
		box = ROW_W'({$urandom, $urandom});
		box[BOX_W-1:0] = {rand_len(), rand_len(), rand_len()};
		write_reg(REG_BOX, box);
		// walk the mode value across the phases, upper bits random
		write_reg(REG_MODE, {{(ROW_W-32){1'b0}}, $urandom} & ~ROW_W'(31)
			| ROW_W'((phase * 7 + $urandom_range(0, 1) * 16) % 32));
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		pos_beats = 0;
		cfg_beats = 0;
		allow_idle = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: Cartesian, nothing periodic; field extremes
		send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		send_position(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		drain();

		// periodic centred window, one zero-length axis
		write_reg(REG_BOX, ROW_W'({20'd0, 20'd10240, 20'd1}));
		write_reg(REG_MODE, ROW_W'(5'b01111));
		send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_position(32'h0028_0000, 32'hFFD8_0000, 32'h1234_5678);
		send_position(32'h0000_0020, 32'hFFFF_FFE0, 32'h0);
		drain();

		// positive window, full box lengths
		write_reg(REG_BOX, ROW_W'({20'hFFFFF, 20'hFFFFF, 20'hFFFFF}));
		write_reg(REG_MODE, ROW_W'(5'b11111));
		send_position(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_position(32'h0, 32'h3FFF_FFC0, 32'hC000_0040);
		drain();

		// unknown index must leave the settings alone
		write_reg(CFG_IDX_W'(int'(REG_MODE) + 1), '1);
		write_reg('1, '0);
		send_position(32'h0001_0000, 32'hFFFF_0000, 32'h0);
		drain();

		// skewed cell with extreme forward elements: saturation
		write_reg(REG_FWD0, {3{21'h0FFFFF}});
		write_reg(REG_FWD1, {3{21'h100000}});
		write_reg(REG_FWD2, {21'h0FFFFF, 21'h100000, 21'h0});
		write_reg(REG_MODE, ROW_W'(5'b00000));
		send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_position(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000);
		drain();
		write_reg(REG_MODE, ROW_W'(5'b10111));
		send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_position(32'h0123_4567, 32'hFEDC_BA98, 32'h7FFF_0000);
		drain();

		// random phases; the last one runs without idling
		for (int ph = 0; ph < N_PHASES; ph++) begin
			random_config(ph);
			allow_idle = (ph != N_PHASES - 1);
			for (int n = 0; n < PHASE_BEATS; n++)
				send_position(rand_coord(0), rand_coord(1), rand_coord(2));
			drain();
		end

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("** periodic_box_position_wrap: PASSED **");
		end else begin
			$display("** periodic_box_position_wrap: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("** periodic_box_position_wrap: FAILED **");
		$finish;
	end

endmodule
